// ===== design/vgnu_pkg.sv =====
package vgnu_pkg;

    localparam int MAX_GRID_N = 16;
    localparam int IDX_W      = (MAX_GRID_N > 1) ? $clog2(MAX_GRID_N) : 1;
    localparam int N_W        = IDX_W + 1;
    localparam int CELLS      = MAX_GRID_N * MAX_GRID_N;
    localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 12;
    localparam int GRID_N_W   = 5;
    localparam int TGT_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // mark: running multiple of the cell size compared against the offset
    localparam int ACC_W      = SIZE_W + N_W;
    localparam int MCMP_W     = (ACC_W > COORD_W) ? ACC_W : COORD_W;

    // query: doubled offset to a cell centre, its square, and the sum of two
    localparam int EX_W       = SIZE_W + N_W + 2;
    localparam int SQ_W       = 2 * EX_W;
    localparam int DIST_W     = SQ_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_N      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd4;

    localparam logic [GRID_N_W-1:0] GRID_N_RESET      = 5'd8;
    localparam logic [SIZE_W-1:0]   CELL_WIDTH_RESET  = 12'd256;
    localparam logic [SIZE_W-1:0]   CELL_HEIGHT_RESET = 12'd256;

    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_QROW,
        ST_QCELL,
        ST_QDRAIN,
        ST_QDONE
    } state_t;

endpackage

// ===== design/visited_grid_nearest_unvisited.sv =====
// Mark request: after accept, the cell size is stepped along the column, then the row, up to n = min(grid_n,
// 16); a mark left of or below the grid, at n = 0 or with a zero cell size ends at accept.
// Query request: rows are scanned in turn, then a drain step and a done step; one shared squaring
// multiplier serves the row term once per row and one cell per cycle after it.
// One request at a time; in_ready is high only while idle. A result waits in an output
// register and a following mark proceeds meanwhile.
// Reset (async, active low) clears all visited bits and loads the register defaults.
module visited_grid_nearest_unvisited (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [vgnu_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [vgnu_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    func,
    input  logic signed [vgnu_pkg::COORD_W-1:0]     pos_x,
    input  logic signed [vgnu_pkg::COORD_W-1:0]     pos_y,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [vgnu_pkg::TGT_W-1:0]       target_x,
    output logic signed [vgnu_pkg::TGT_W-1:0]       target_y,
    output logic                                    found
);

    localparam int MAX_GRID_N = vgnu_pkg::MAX_GRID_N;
    localparam int IDX_W      = vgnu_pkg::IDX_W;
    localparam int N_W        = vgnu_pkg::N_W;
    localparam int CELLS      = vgnu_pkg::CELLS;
    localparam int CELL_W     = vgnu_pkg::CELL_W;
    localparam int COORD_W    = vgnu_pkg::COORD_W;
    localparam int SIZE_W     = vgnu_pkg::SIZE_W;
    localparam int GRID_N_W   = vgnu_pkg::GRID_N_W;
    localparam int TGT_W      = vgnu_pkg::TGT_W;
    localparam int MCMP_W     = vgnu_pkg::MCMP_W;
    localparam int EX_W       = vgnu_pkg::EX_W;
    localparam int SQ_W       = vgnu_pkg::SQ_W;
    localparam int DIST_W     = vgnu_pkg::DIST_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int NCMP_W     = (GRID_N_W > N_W) ? GRID_N_W : N_W;

    // configuration
    logic [GRID_N_W-1:0]        grid_n_reg;
    logic [SIZE_W-1:0]          cell_width_reg;
    logic [SIZE_W-1:0]          cell_height_reg;
    logic signed [COORD_W-1:0]  origin_x_reg;
    logic signed [COORD_W-1:0]  origin_y_reg;

    logic [CELLS-1:0]           visited_reg, visited_next;
    vgnu_pkg::state_t           state_reg, state_next;
    logic [N_W-1:0]             n_reg, n_next;

    // mark sequencer
    logic [COORD_W-1:0]         mdx_reg, mdx_next;
    logic [COORD_W-1:0]         mdy_reg, mdy_next;
    logic                       axis_reg, axis_next;
    logic [MCMP_W-1:0]          acc_reg, acc_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic [N_W-1:0]             cnt_reg, cnt_next;
    logic [N_W-1:0]             mcol_reg, mcol_next;

    // query sequencer
    logic signed [EX_W-1:0]     ex0_reg, ex0_next;
    logic signed [EX_W-1:0]     ex_reg, ex_next;
    logic signed [EX_W-1:0]     ey_reg, ey_next;
    logic [TGT_W-1:0]           cx0_reg, cx0_next;
    logic [TGT_W-1:0]           cx_reg, cx_next;
    logic [TGT_W-1:0]           cy_reg, cy_next;
    logic [IDX_W-1:0]           qc_reg, qc_next;
    logic [IDX_W-1:0]           qr_reg, qr_next;
    logic [SQ_W-1:0]            ey2_reg, ey2_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [TGT_W-1:0]           s1_cx_reg, s1_cx_next;
    logic [TGT_W-1:0]           s1_cy_reg, s1_cy_next;
    logic [DIST_W-1:0]          best_reg, best_next;
    logic                       hit_reg, hit_next;
    logic [TGT_W-1:0]           bx_reg, bx_next;
    logic [TGT_W-1:0]           by_reg, by_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [TGT_W-1:0]           tx_out_reg, tx_out_next;
    logic [TGT_W-1:0]           ty_out_reg, ty_out_next;
    logic                       found_out_reg, found_out_next;

    // combinational helpers
    logic signed [DIFF_W-1:0]   diff_x, diff_y;
    logic [N_W-1:0]             n_clamp;
    logic [TGT_W-1:0]           ox_ext, oy_ext;
    logic [COORD_W-1:0]         mdsel;
    logic                       mhit;
    logic [N_W-1:0]             mcnt_fin;
    logic [N_W-1:0]             n_m1;
    logic                       step_last, qc_last, qr_last;
    logic [CELL_W-1:0]          mark_idx, scan_idx;
    logic signed [EX_W-1:0]     mult_a;
    logic signed [SQ_W-1:0]     prod;
    logic [DIST_W-1:0]          cell_dist;
    logic                       better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_n_reg      <= vgnu_pkg::GRID_N_RESET;
            cell_width_reg  <= vgnu_pkg::CELL_WIDTH_RESET;
            cell_height_reg <= vgnu_pkg::CELL_HEIGHT_RESET;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vgnu_pkg::REG_GRID_N:      grid_n_reg      <= cfg_data[GRID_N_W-1:0];
                vgnu_pkg::REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[SIZE_W-1:0];
                vgnu_pkg::REG_CELL_HEIGHT: cell_height_reg <= cfg_data[SIZE_W-1:0];
                vgnu_pkg::REG_ORIGIN_X:    origin_x_reg    <= $signed(cfg_data[COORD_W-1:0]);
                vgnu_pkg::REG_ORIGIN_Y:    origin_y_reg    <= $signed(cfg_data[COORD_W-1:0]);
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg   <= '0;
            state_reg     <= vgnu_pkg::ST_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            visited_reg   <= visited_next;
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        mdx_reg       <= mdx_next;
        mdy_reg       <= mdy_next;
        axis_reg      <= axis_next;
        acc_reg       <= acc_next;
        step_reg      <= step_next;
        cnt_reg       <= cnt_next;
        mcol_reg      <= mcol_next;
        ex0_reg       <= ex0_next;
        ex_reg        <= ex_next;
        ey_reg        <= ey_next;
        cx0_reg       <= cx0_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        qc_reg        <= qc_next;
        qr_reg        <= qr_next;
        ey2_reg       <= ey2_next;
        sq_reg        <= sq_next;
        s1_cx_reg     <= s1_cx_next;
        s1_cy_reg     <= s1_cy_next;
        best_reg      <= best_next;
        hit_reg       <= hit_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        tx_out_reg    <= tx_out_next;
        ty_out_reg    <= ty_out_next;
        found_out_reg <= found_out_next;
    end

    always_comb
    begin
        diff_x  = DIFF_W'(pos_x) - DIFF_W'(origin_x_reg);
        diff_y  = DIFF_W'(pos_y) - DIFF_W'(origin_y_reg);
        n_clamp = (NCMP_W'(grid_n_reg) > NCMP_W'(MAX_GRID_N)) ? N_W'(MAX_GRID_N)
                                                               : N_W'(grid_n_reg);
        ox_ext  = TGT_W'(origin_x_reg);
        oy_ext  = TGT_W'(origin_y_reg);
        n_m1    = n_reg - N_W'(1);

        // mark: count the multiples of the cell size that fit in the offset
        mdsel     = axis_reg ? mdy_reg : mdx_reg;
        mhit      = MCMP_W'(mdsel) >= acc_reg;
        mcnt_fin  = cnt_reg + N_W'(mhit);
        step_last = N_W'(step_reg) == n_m1;
        mark_idx  = CELL_W'(mcnt_fin[IDX_W-1:0]) * CELL_W'(MAX_GRID_N)
                  + CELL_W'(mcol_reg[IDX_W-1:0]);

        // query scan
        qc_last   = N_W'(qc_reg) == n_m1;
        qr_last   = N_W'(qr_reg) == n_m1;
        scan_idx  = CELL_W'(qr_reg) * CELL_W'(MAX_GRID_N) + CELL_W'(qc_reg);
        mult_a    = (state_reg == vgnu_pkg::ST_QROW) ? ey_reg : ex_reg;
        prod      = SQ_W'(mult_a) * SQ_W'(mult_a);
        cell_dist = DIST_W'(sq_reg) + DIST_W'(ey2_reg);
        better    = s1_valid_reg && (!hit_reg || cell_dist < best_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        n_next         = n_reg;
        mdx_next       = mdx_reg;
        mdy_next       = mdy_reg;
        axis_next      = axis_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        mcol_next      = mcol_reg;
        ex0_next       = ex0_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        cx0_next       = cx0_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        qc_next        = qc_reg;
        qr_next        = qr_reg;
        ey2_next       = ey2_reg;
        sq_next        = sq_reg;
        s1_valid_next  = 1'b0;
        s1_cx_next     = s1_cx_reg;
        s1_cy_next     = s1_cy_reg;
        best_next      = best_reg;
        hit_next       = hit_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tx_out_next    = tx_out_reg;
        ty_out_next    = ty_out_reg;
        found_out_next = found_out_reg;

        // compare stage, in the cycle after the multiplier
        if (better)
        begin
            hit_next  = 1'b1;
            best_next = cell_dist;
            bx_next   = s1_cx_reg;
            by_next   = s1_cy_reg;
        end

        unique case (state_reg)
            vgnu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = n_clamp;
                    if (func == vgnu_pkg::FUNC_MARK)
                    begin
                        mdx_next  = diff_x[COORD_W-1:0];
                        mdy_next  = diff_y[COORD_W-1:0];
                        axis_next = 1'b0;
                        acc_next  = MCMP_W'(cell_width_reg);
                        step_next = '0;
                        cnt_next  = '0;
                        if (n_clamp != '0 && cell_width_reg != '0 && cell_height_reg != '0
                            && !diff_x[DIFF_W-1] && !diff_y[DIFF_W-1])
                        begin
                            state_next = vgnu_pkg::ST_MARK;
                        end
                    end
                    else
                    begin
                        ex0_next = (EX_W'(diff_x) <<< 1) - $signed(EX_W'(cell_width_reg));
                        ey_next  = (EX_W'(diff_y) <<< 1) - $signed(EX_W'(cell_height_reg));
                        cx0_next = ox_ext + TGT_W'(cell_width_reg >> 1);
                        cy_next  = oy_ext + TGT_W'(cell_height_reg >> 1);
                        qr_next  = '0;
                        hit_next = 1'b0;
                        bx_next  = ox_ext;
                        by_next  = oy_ext;
                        state_next = (n_clamp == '0) ? vgnu_pkg::ST_QDONE
                                                     : vgnu_pkg::ST_QROW;
                    end
                end
            end

            vgnu_pkg::ST_MARK:
            begin
                cnt_next  = mcnt_fin;
                acc_next  = acc_reg + MCMP_W'(axis_reg ? cell_height_reg : cell_width_reg);
                step_next = step_reg + IDX_W'(1);
                if (step_last)
                begin
                    if (!axis_reg)
                    begin
                        mcol_next = mcnt_fin;
                        axis_next = 1'b1;
                        acc_next  = MCMP_W'(cell_height_reg);
                        step_next = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        if (mcol_reg < n_reg && mcnt_fin < n_reg)
                        begin
                            visited_next[mark_idx] = 1'b1;
                        end
                        state_next = vgnu_pkg::ST_IDLE;
                    end
                end
            end

            vgnu_pkg::ST_QROW:
            begin
                ey2_next   = prod[SQ_W-1:0];
                ex_next    = ex0_reg;
                cx_next    = cx0_reg;
                qc_next    = '0;
                state_next = vgnu_pkg::ST_QCELL;
            end

            vgnu_pkg::ST_QCELL:
            begin
                sq_next       = prod[SQ_W-1:0];
                s1_valid_next = !visited_reg[scan_idx];
                s1_cx_next    = cx_reg;
                s1_cy_next    = cy_reg;
                ex_next       = ex_reg - $signed(EX_W'({cell_width_reg, 1'b0}));
                cx_next       = cx_reg + TGT_W'(cell_width_reg);
                qc_next       = qc_reg + IDX_W'(1);
                if (qc_last)
                begin
                    if (qr_last)
                    begin
                        state_next = vgnu_pkg::ST_QDRAIN;
                    end
                    else
                    begin
                        qr_next    = qr_reg + IDX_W'(1);
                        ey_next    = ey_reg - $signed(EX_W'({cell_height_reg, 1'b0}));
                        cy_next    = cy_reg + TGT_W'(cell_height_reg);
                        state_next = vgnu_pkg::ST_QROW;
                    end
                end
            end

            vgnu_pkg::ST_QDRAIN:
            begin
                state_next = vgnu_pkg::ST_QDONE;
            end

            vgnu_pkg::ST_QDONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    tx_out_next    = bx_reg;
                    ty_out_next    = by_reg;
                    found_out_next = hit_reg;
                    state_next     = vgnu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vgnu_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = state_reg == vgnu_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign target_x  = $signed(tx_out_reg);
    assign target_y  = $signed(ty_out_reg);
    assign found     = found_out_reg;

    a_visited_only_set: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(visited_reg) >= $past($countones(visited_reg)))
        else $error("visited bit cleared");

    a_compare_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == vgnu_pkg::ST_QCELL))
        else $error("compare stage loaded outside the cell scan");

    a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vgnu_pkg::ST_QCELL |-> (N_W'(qc_reg) < n_reg && N_W'(qr_reg) < n_reg))
        else $error("scan index outside active grid");

    a_empty_gives_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && !found_out_reg) |->
        (tx_out_reg == TGT_W'(origin_x_reg) && ty_out_reg == TGT_W'(origin_y_reg)))
        else $error("no unvisited cell but target is not the origin");

endmodule
